// ----- hdl/skf_pkg.sv -----
// skf_pkg: widths, register indexes and controller commands for the scalar kalman filter
// used by skf_ctrl, skf_dp and scalar_kalman_filter_top; depends on nothing
`default_nettype none

package skf_pkg;

	localparam int DATA_W   = 32;
	localparam int GAIN_W   = 16;
	localparam int GAIN_OUT_W = GAIN_W + 1;
	localparam int DIV_STEPS = GAIN_W;
	localparam int CNT_W    = $clog2(DIV_STEPS);
	localparam int PROD_W   = DATA_W + GAIN_OUT_W;

	localparam logic [GAIN_OUT_W-1:0] GAIN_ONE = GAIN_OUT_W'(1) << GAIN_W;

	// register indexes
	localparam logic REG_PROCESS_NOISE = 1'b0;
	localparam logic REG_MEASURE_NOISE = 1'b1;

	localparam logic [DATA_W-1:0] PROCESS_NOISE_RST = 32'd1310720;
	localparam logic [DATA_W-1:0] MEASURE_NOISE_RST = 32'd13107200;

	typedef struct packed {
		logic load;      // capture request, form predicted covariance
		logic prep;      // set up divider and difference magnitude
		logic div_step;  // one restoring division step
		logic mul_est;   // gain times magnitude
		logic mul_cov;   // predicted covariance times one minus gain
		logic commit;    // write state and result registers
	} cmd_t;

endpackage

`default_nettype wire

// ----- hdl/skf_dp.sv -----
// skf_dp: datapath of the scalar kalman filter: noise registers, state, divider,
// shared multiplier and result registers; depends on skf_pkg
`default_nettype none

module skf_dp (
	input  wire                                   clk,
	input  wire                                   arst_n,
	input  wire                                   write_enable,
	input  wire                                   reg_index,
	input  wire        [skf_pkg::DATA_W-1:0]      write_data,
	input  wire                                   mode,
	input  wire signed [skf_pkg::DATA_W-1:0]      measurement,
	input  skf_pkg::cmd_t                         cmd,
	output logic signed [skf_pkg::DATA_W-1:0]     estimate,
	output logic       [skf_pkg::GAIN_OUT_W-1:0]  gain,
	output logic       [skf_pkg::DATA_W-1:0]      covariance
);

	logic [skf_pkg::DATA_W-1:0]        q_q, r_q;
	logic signed [skf_pkg::DATA_W-1:0] last_est_q;
	logic [skf_pkg::DATA_W-1:0]        last_cov_q;

	logic                              clear_q;
	logic signed [skf_pkg::DATA_W-1:0] meas_q;
	logic [skf_pkg::DATA_W-1:0]        pm_q;
	logic [skf_pkg::DATA_W:0]          den_q;
	logic [skf_pkg::DATA_W:0]          rem_q;
	logic [skf_pkg::GAIN_W-1:0]        quo_q;
	logic                              zero_pm_q, zero_r_q;
	logic [skf_pkg::DATA_W-1:0]        mag_q;
	logic                              up_q;
	logic [skf_pkg::PROD_W-1:0]        prod_q;
	logic signed [skf_pkg::DATA_W-1:0] est_new_q;

	logic [skf_pkg::DATA_W:0]          sum;
	logic [skf_pkg::DATA_W-1:0]        pm_next;
	logic [skf_pkg::DATA_W+1:0]        rem_sh, rem_diff;
	logic                              rem_ge;
	logic [skf_pkg::GAIN_OUT_W-1:0]    gain_cur;
	logic [skf_pkg::DATA_W-1:0]        mul_a;
	logic [skf_pkg::GAIN_OUT_W-1:0]    mul_b;
	logic [skf_pkg::PROD_W-1:0]        product;
	logic [skf_pkg::DATA_W-1:0]        scaled;

	// saturating prediction of the covariance
	assign sum     = {1'b0, last_cov_q} + {1'b0, q_q};
	assign pm_next = sum[skf_pkg::DATA_W] ? '1 : sum[skf_pkg::DATA_W-1:0];

	assign rem_sh   = {rem_q, 1'b0};
	assign rem_diff = rem_sh - {1'b0, den_q};
	assign rem_ge   = (rem_sh >= {1'b0, den_q});

	always_comb begin
		priority if (zero_pm_q) begin
			gain_cur = '0;
		end else if (zero_r_q) begin
			gain_cur = skf_pkg::GAIN_ONE;
		end else begin
			gain_cur = {1'b0, quo_q};
		end
	end

	// one multiplier shared by the estimate and covariance updates
	assign mul_a   = cmd.mul_cov ? pm_q : mag_q;
	assign mul_b   = cmd.mul_cov ? (skf_pkg::GAIN_ONE - gain_cur) : gain_cur;
	assign product = {{skf_pkg::GAIN_OUT_W{1'b0}}, mul_a} * {{skf_pkg::DATA_W{1'b0}}, mul_b};
	assign scaled  = prod_q[skf_pkg::GAIN_W +: skf_pkg::DATA_W];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			q_q        <= skf_pkg::PROCESS_NOISE_RST;
			r_q        <= skf_pkg::MEASURE_NOISE_RST;
			last_est_q <= '0;
			last_cov_q <= '0;
		end else begin
			if (write_enable) begin
				unique case (reg_index)
					skf_pkg::REG_PROCESS_NOISE: q_q <= write_data;
					skf_pkg::REG_MEASURE_NOISE: r_q <= write_data;
					default: ;
				endcase
			end
			if (cmd.commit) begin
				last_est_q <= clear_q ? '0 : est_new_q;
				last_cov_q <= clear_q ? '0 : scaled;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			clear_q <= mode;
			meas_q  <= measurement;
			pm_q    <= pm_next;
		end
		if (cmd.prep) begin
			den_q     <= {1'b0, pm_q} + {1'b0, r_q};
			rem_q     <= {1'b0, pm_q};
			quo_q     <= '0;
			zero_pm_q <= (pm_q == '0);
			zero_r_q  <= (r_q == '0);
			if (meas_q >= last_est_q) begin
				mag_q <= meas_q - last_est_q;
				up_q  <= 1'b1;
			end else begin
				mag_q <= last_est_q - meas_q;
				up_q  <= 1'b0;
			end
		end
		if (cmd.div_step) begin
			rem_q <= rem_ge ? rem_diff[skf_pkg::DATA_W:0] : rem_sh[skf_pkg::DATA_W:0];
			quo_q <= {quo_q[skf_pkg::GAIN_W-2:0], rem_ge};
		end
		if (cmd.mul_est || cmd.mul_cov) begin
			prod_q <= product;
		end
		if (cmd.mul_cov) begin
			est_new_q <= up_q ? (last_est_q + scaled) : (last_est_q - scaled);
		end
		if (cmd.commit) begin
			estimate   <= clear_q ? '0 : est_new_q;
			gain       <= clear_q ? '0 : gain_cur;
			covariance <= clear_q ? '0 : scaled;
		end
	end

endmodule

`default_nettype wire

// ----- hdl/skf_ctrl.sv -----
// skf_ctrl: controller of the scalar kalman filter: sequences load, division,
// multiplies and commit, and owns the request handshakes; depends on skf_pkg
`default_nettype none

module skf_ctrl (
	input  wire           clk,
	input  wire           arst_n,
	input  wire           in_valid,
	output logic          in_ready,
	input  wire           mode,
	output logic          out_valid,
	input  wire           out_ready,
	output skf_pkg::cmd_t cmd
);

	typedef enum logic [2:0] {
		IDLE,
		PREP,
		DIV,
		MUL_EST,
		MUL_COV,
		FINISH
	} state_t;

	state_t                    state_q;
	logic [skf_pkg::CNT_W-1:0] cnt_q;
	logic                      out_valid_q;
	logic                      slot_free;

	assign slot_free = !out_valid_q || out_ready;
	assign in_ready  = (state_q == IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		cmd          = '0;
		cmd.load     = in_valid && (state_q == IDLE);
		cmd.prep     = (state_q == PREP);
		cmd.div_step = (state_q == DIV);
		cmd.mul_est  = (state_q == MUL_EST);
		cmd.mul_cov  = (state_q == MUL_COV);
		cmd.commit   = (state_q == FINISH) && slot_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			// a commit in the same cycle refills the output register instead
			if (out_valid_q && out_ready && !cmd.commit) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				IDLE: begin
					if (in_valid) begin
						// a clear request skips the arithmetic
						state_q <= mode ? FINISH : PREP;
					end
				end
				PREP: begin
					cnt_q   <= '0;
					state_q <= DIV;
				end
				DIV: begin
					if (cnt_q == skf_pkg::CNT_W'(skf_pkg::DIV_STEPS - 1)) begin
						cnt_q   <= '0;
						state_q <= MUL_EST;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				MUL_EST: state_q <= MUL_COV;
				MUL_COV: state_q <= FINISH;
				FINISH: begin
					if (slot_free) begin
						out_valid_q <= 1'b1;
						state_q     <= IDLE;
					end
				end
				default: state_q <= IDLE;
			endcase
		end
	end

	// result written only into a free output register
	a_commit_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |-> (!out_valid_q || out_ready))
		else $error("commit while output register still held");

	a_commit_shows: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |=> out_valid_q)
		else $error("commit not followed by a valid result");

	a_load_next: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |=> (state_q == PREP || state_q == FINISH))
		else $error("accepted request did not start");

	a_cnt_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != DIV) |-> (cnt_q == '0))
		else $error("division counter not cleared outside division");

endmodule

`default_nettype wire

// ----- hdl/scalar_kalman_filter_top.sv -----
// scalar kalman filter top level: ties the controller to the datapath
// depends on skf_pkg, skf_ctrl and skf_dp
// a filter request runs load, prep, the restoring gain division, both multiplies and commit;
// the divider takes 16 steps, and a new request is accepted only once the block is back in idle;
// a clear skips to commit; a result still held in the output register delays the commit
// reset: noise registers to 20.0 and 200.0, estimate and covariance to zero, no result held
`default_nettype none

module scalar_kalman_filter_top (
	input  wire                                   clk,
	input  wire                                   arst_n,
	input  wire                                   write_enable,
	input  wire                                   reg_index,
	input  wire        [skf_pkg::DATA_W-1:0]      write_data,
	input  wire                                   in_valid,
	output logic                                  in_ready,
	input  wire                                   mode,
	input  wire signed [skf_pkg::DATA_W-1:0]      measurement,
	output logic                                  out_valid,
	input  wire                                   out_ready,
	output logic signed [skf_pkg::DATA_W-1:0]     estimate,
	output logic       [skf_pkg::GAIN_OUT_W-1:0]  gain,
	output logic       [skf_pkg::DATA_W-1:0]      covariance
);

	skf_pkg::cmd_t cmd;

	skf_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.mode      (mode),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.cmd       (cmd)
	);

	skf_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.write_enable (write_enable),
		.reg_index    (reg_index),
		.write_data   (write_data),
		.mode         (mode),
		.measurement  (measurement),
		.cmd          (cmd),
		.estimate     (estimate),
		.gain         (gain),
		.covariance   (covariance)
	);

endmodule

`default_nettype wire

// ----- bench/skf_test_pkg.sv -----
// skf_test_pkg: request mode codes shared by the scalar kalman filter bench files
// used by skf_output_checker and scalar_kalman_filter_top_test; depends on nothing

package skf_test_pkg;

	localparam logic MODE_FILTER = 1'b0;
	localparam logic MODE_CLEAR  = 1'b1;

endpackage

// ----- bench/skf_output_checker.sv -----
// skf_output_checker: follows register writes and requests, predicts every filter result
// and compares it with what the block hands out; depends on skf_pkg and skf_test_pkg

module skf_output_checker (
	input  wire                                   clk,
	input  wire                                   arst_n,
	input  wire                                   write_enable,
	input  wire                                   reg_index,
	input  wire        [skf_pkg::DATA_W-1:0]      write_data,
	input  wire                                   in_valid,
	input  wire                                   in_ready,
	input  wire                                   mode,
	input  wire signed [skf_pkg::DATA_W-1:0]      measurement,
	input  wire                                   out_valid,
	input  wire                                   out_ready,
	input  wire signed [skf_pkg::DATA_W-1:0]      estimate,
	input  wire        [skf_pkg::GAIN_OUT_W-1:0]  gain,
	input  wire        [skf_pkg::DATA_W-1:0]      covariance,
	output int                                    fail_count,
	output int                                    pending
);

	import skf_pkg::*;
	import skf_test_pkg::*;

	typedef struct packed {
		logic [DATA_W-1:0]     estimate;
		logic [GAIN_OUT_W-1:0] gain;
		logic [DATA_W-1:0]     covariance;
	} filter_result_t;

	logic [DATA_W-1:0] q_noise;
	logic [DATA_W-1:0] r_noise;
	logic [DATA_W-1:0] est_state;
	logic [DATA_W-1:0] cov_state;
	filter_result_t    filter_results_q[$];
	filter_result_t    predicted;
	filter_result_t    want;
	int                mismatches = 0;

	assign fail_count = mismatches;

	function automatic filter_result_t filter_sample(input logic [DATA_W-1:0] x,
			input logic [DATA_W-1:0] p, input logic [DATA_W-1:0] q,
			input logic [DATA_W-1:0] r, input logic [DATA_W-1:0] z);
		logic [DATA_W:0]   sum;
		logic [DATA_W-1:0] pm;
		logic [DATA_W-1:0] zb;
		logic [DATA_W-1:0] xb;
		logic [DATA_W-1:0] mag;
		logic [63:0]       k;
		logic [63:0]       prod;
		filter_result_t    res;
		sum = {1'b0, p} + {1'b0, q};
		pm = sum[DATA_W] ? '1 : sum[DATA_W-1:0];
		if (pm == '0)
			k = '0;
		else if (r == '0)
			k = 64'(GAIN_ONE);
		else
			k = (64'(pm) << GAIN_W) / (64'(pm) + 64'(r));
		if (k > 64'(GAIN_ONE))
			k = 64'(GAIN_ONE);
		// offset binary so an unsigned compare orders the signed values
		zb = {~z[DATA_W-1], z[DATA_W-2:0]};
		xb = {~x[DATA_W-1], x[DATA_W-2:0]};
		if (zb >= xb) begin
			mag = zb - xb;
			prod = 64'(mag) * k;
			res.estimate = x + prod[GAIN_W +: DATA_W];
		end else begin
			mag = xb - zb;
			prod = 64'(mag) * k;
			res.estimate = x - prod[GAIN_W +: DATA_W];
		end
		prod = 64'(pm) * (64'(GAIN_ONE) - k);
		res.covariance = prod[GAIN_W +: DATA_W];
		res.gain = k[GAIN_OUT_W-1:0];
		return res;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			q_noise = PROCESS_NOISE_RST;
			r_noise = MEASURE_NOISE_RST;
			est_state = '0;
			cov_state = '0;
			filter_results_q.delete();
			pending <= 0;
		end else begin
			if (write_enable) begin
				if (reg_index == REG_PROCESS_NOISE)
					q_noise = write_data;
				else
					r_noise = write_data;
			end
			if (in_valid && in_ready) begin
				if (mode == MODE_CLEAR)
					predicted = '0;
				else
					predicted = filter_sample(est_state, cov_state, q_noise, r_noise,
						measurement);
				est_state = predicted.estimate;
				cov_state = predicted.covariance;
				filter_results_q.push_back(predicted);
			end
			if (out_valid && out_ready) begin
				if (filter_results_q.size() == 0) begin
					$error("result with no request waiting: estimate %0d gain %0d covariance %0d",
						estimate, gain, covariance);
					mismatches++;
				end else begin
					want = filter_results_q.pop_front();
					if (estimate !== want.estimate) begin
						$error("estimate: expected %0d, got %0d", $signed(want.estimate), estimate);
						mismatches++;
					end
					if (gain !== want.gain) begin
						$error("gain: expected %0d, got %0d", want.gain, gain);
						mismatches++;
					end
					if (covariance !== want.covariance) begin
						$error("covariance: expected %0d, got %0d", want.covariance, covariance);
						mismatches++;
					end
				end
			end
			// registered so the stimulus side never races the queue update
			pending <= filter_results_q.size();
		end
	end

endmodule

// ----- bench/scalar_kalman_filter_top_test.sv -----
// scalar_kalman_filter_top_test: directed and random requests under several idling mixes
// depends on skf_pkg, skf_test_pkg, skf_output_checker and scalar_kalman_filter_top

module scalar_kalman_filter_top_test;

	import skf_pkg::*;
	import skf_test_pkg::*;

	localparam int IDLE_LIMIT    = 4000;
	localparam int SETTLE_CYCLES = 30;
	localparam int BLOCK_ITEMS   = 75;

	logic                         clk = 1'b0;
	logic                         arst_n = 1'b0;
	logic                         write_enable = 1'b0;
	logic                         reg_index = 1'b0;
	logic        [DATA_W-1:0]     write_data = '0;
	logic                         in_valid = 1'b0;
	logic                         mode = MODE_FILTER;
	logic signed [DATA_W-1:0]     measurement = '0;
	logic                         out_ready = 1'b0;
	wire                          in_ready;
	wire                          out_valid;
	wire signed  [DATA_W-1:0]     estimate;
	wire         [GAIN_OUT_W-1:0] gain;
	wire         [DATA_W-1:0]     covariance;
	int                           fail_count;
	int                           pending;
	int                           idle_pct = 0;
	int                           stall_pct = 0;
	int                           quiet_cycles = 0;
	int                           trend = 0;

	scalar_kalman_filter_top u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.write_enable (write_enable),
		.reg_index    (reg_index),
		.write_data   (write_data),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.mode         (mode),
		.measurement  (measurement),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.estimate     (estimate),
		.gain         (gain),
		.covariance   (covariance)
	);

	skf_output_checker u_checker (
		.clk          (clk),
		.arst_n       (arst_n),
		.write_enable (write_enable),
		.reg_index    (reg_index),
		.write_data   (write_data),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.mode         (mode),
		.measurement  (measurement),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.estimate     (estimate),
		.gain         (gain),
		.covariance   (covariance),
		.fail_count   (fail_count),
		.pending      (pending)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	always @(posedge clk) begin
		out_ready <= ($urandom_range(99) >= stall_pct);
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= IDLE_LIMIT) begin
			$display("*** FAILED ***");
			$finish;
		end
	end

	// valid stays up across back-to-back requests, dropped only for a gap
	task automatic send_request(input logic m, input logic [DATA_W-1:0] z);
		while ($urandom_range(99) < idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		mode <= m;
		measurement <= z;
		do @(posedge clk); while (!in_ready);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
	endtask

	task automatic write_noise(input logic [DATA_W-1:0] q, input logic [DATA_W-1:0] r);
		drain();
		write_enable <= 1'b1;
		reg_index <= REG_PROCESS_NOISE;
		write_data <= q;
		@(posedge clk);
		reg_index <= REG_MEASURE_NOISE;
		write_data <= r;
		@(posedge clk);
		write_enable <= 1'b0;
	endtask

	function automatic logic [DATA_W-1:0] pick_noise();
		case ($urandom_range(9))
			0:       return '0;
			1:       return '1;
			2, 3:    return $urandom_range(32'h0010_0000);
			4, 5, 6: return $urandom_range(32'h0400_0000, 32'h0001_0000);
			default: return $urandom();
		endcase
	endfunction

	initial begin
		int sel;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings, extremes of the sample and a clear with junk in the sample
		send_request(MODE_FILTER, 32'h0000_0000);
		send_request(MODE_FILTER, 32'h7FFF_FFFF);
		send_request(MODE_FILTER, 32'h8000_0000);
		send_request(MODE_FILTER, 32'hFFFF_FFFF);
		send_request(MODE_FILTER, 32'h0000_0001);
		send_request(MODE_CLEAR, 32'hFFFF_FFFF);
		send_request(MODE_FILTER, 32'h1234_5678);
		// no measurement noise: full gain
		write_noise(PROCESS_NOISE_RST, '0);
		send_request(MODE_FILTER, 32'h8000_0000);
		send_request(MODE_FILTER, 32'h7FFF_FFFF);
		// nothing in either noise: zero denominator after a clear
		write_noise('0, '0);
		send_request(MODE_CLEAR, 32'h5A5A_A5A5);
		send_request(MODE_FILTER, 32'h5555_5555);
		send_request(MODE_FILTER, 32'hFFFF_EDCC);
		// saturating prediction
		write_noise('1, '1);
		send_request(MODE_FILTER, 32'h7FFF_FFFF);
		send_request(MODE_FILTER, 32'h8000_0000);
		send_request(MODE_FILTER, 32'h0001_0000);
		write_noise(32'd1, '1);
		send_request(MODE_FILTER, 32'h0001_0000);
		send_request(MODE_FILTER, 32'hFFFF_0000);
		write_noise('1, '0);
		send_request(MODE_FILTER, 32'hAAAA_AAAA);
		send_request(MODE_FILTER, 32'h0000_0000);

		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
				0:       begin idle_pct = 0;  stall_pct = 0;  end
				1:       begin idle_pct = 53; stall_pct = 0;  end
				2:       begin idle_pct = 0;  stall_pct = 53; end
				default: begin idle_pct = 18; stall_pct = 18; end
			endcase
			for (int blk = 0; blk < 3; blk++) begin
				write_noise(pick_noise(), pick_noise());
				for (int n = 0; n < BLOCK_ITEMS; n++) begin
					if (ph == 2 && blk == 1 && n == BLOCK_ITEMS / 2)
						drain();
					sel = $urandom_range(99);
					if (sel < 4) begin
						send_request(MODE_CLEAR, $urandom());
					end else if (sel < 70) begin
						// slowly drifting signal with sensor noise on top
						trend = trend + int'($urandom_range(32'h0001_0000)) - 32'h0000_8000;
						send_request(MODE_FILTER,
							trend + int'($urandom_range(32'h0008_0000)) - 32'h0004_0000);
					end else if (sel < 75) begin
						trend = $urandom();
						send_request(MODE_FILTER, trend);
					end else if (sel < 90) begin
						send_request(MODE_FILTER, $urandom());
					end else begin
						case ($urandom_range(3))
							0:       send_request(MODE_FILTER, 32'h7FFF_FFFF);
							1:       send_request(MODE_FILTER, 32'h8000_0000);
							2:       send_request(MODE_FILTER, 32'h0000_0000);
							default: send_request(MODE_FILTER, 32'hFFFF_FFFF);
						endcase
					end
				end
			end
		end

		drain();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (fail_count == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule

// ----- scalar_kalman_filter_top.f -----
hdl/skf_pkg.sv
hdl/skf_dp.sv
hdl/skf_ctrl.sv
hdl/scalar_kalman_filter_top.sv
bench/skf_test_pkg.sv
bench/skf_output_checker.sv
bench/scalar_kalman_filter_top_test.sv
